// ===== src/iol_pkg.sv =====
`timescale 1ns / 1ps

package iol_pkg;

   localparam int NODES  = 64;
   localparam int Links  = NODES + 2;
   localparam int IdxW   = $clog2(NODES);
   localparam int LinkW  = $clog2(Links);
   localparam int CountW = $clog2(NODES + 1);
   localparam int KindW  = 2;

   localparam logic [LinkW-1:0]  HeadIdx  = LinkW'(NODES);
   localparam logic [LinkW-1:0]  EndIdx   = LinkW'(NODES + 1);
   localparam logic [CountW-1:0] CountMax = CountW'(NODES);

   typedef enum logic [KindW-1:0] {
      KIND_UNLINK = 2'd0,
      KIND_APPEND = 2'd1,
      KIND_MOVE   = 2'd2,
      KIND_READ   = 2'd3
   } iol_kind_type;

   // one port pair of a link memory: one write and one registered read per cycle
   typedef struct packed {
      logic             we;
      logic [LinkW-1:0] waddr;
      logic [LinkW-1:0] wdata;
      logic             re;
      logic [LinkW-1:0] raddr;
   } iol_mem_req_type;

   // link values are sentinel or node indices; anything else is treated as end
   function automatic logic [LinkW-1:0] clip_link(input logic [LinkW-1:0] v);
      return (v < LinkW'(Links)) ? v : EndIdx;
   endfunction

endpackage

// ===== src/iol_link_mem.sv =====
`timescale 1ns / 1ps

module iol_link_mem import iol_pkg::*; (
   input  logic                  clock,
   input  iol_mem_req_type       req,
   output logic [LinkW-1:0]      rd_data
);

   logic [LinkW-1:0] mem [Links];
   logic [LinkW-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (req.we) begin
         mem[req.waddr] <= req.wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (req.re) begin
         rd_data_ff <= mem[req.raddr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/iol_ctrl.sv =====
`timescale 1ns / 1ps

module iol_ctrl import iol_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic [KindW-1:0]     req_kind,
   input  logic [IdxW-1:0]      req_node_index,
   output iol_mem_req_type      next_req,
   output iol_mem_req_type      prev_req,
   input  logic [LinkW-1:0]     next_rd,
   input  logic [LinkW-1:0]     prev_rd,
   output logic                 rsp_strobe,
   output logic [LinkW-1:0]     rsp_front_node,
   output logic [LinkW-1:0]     rsp_tail_node,
   output logic [CountW-1:0]    rsp_node_count,
   output logic [LinkW-1:0]     rsp_prev_node,
   output logic [LinkW-1:0]     rsp_next_node
);

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_LINK   = 5'b00010,
      ST_APPEND = 5'b00100,
      ST_TAILW  = 5'b01000,
      ST_RESP   = 5'b10000
   } iol_state_type;

   iol_state_type     state_ff, state_in;
   iol_kind_type      kind_ff, kind_in;
   logic [IdxW-1:0]   node_ff, node_in;
   logic [LinkW-1:0]  tail_ff, tail_in;
   logic [LinkW-1:0]  front_ff, front_in;
   logic [CountW-1:0] count_ff, count_in;
   logic [LinkW-1:0]  pv_ff, pv_in;
   logic [LinkW-1:0]  nv_ff, nv_in;
   logic              strobe_ff, strobe_in;
   logic [LinkW-1:0]  rsp_front_ff, rsp_tail_ff, rsp_prev_ff, rsp_next_ff;
   logic [CountW-1:0] rsp_count_ff;

   logic [LinkW-1:0]  node_link;
   logic [LinkW-1:0]  p_link;
   logic [LinkW-1:0]  n_link;

   assign node_link = LinkW'(node_ff);
   assign p_link    = clip_link(prev_rd);
   assign n_link    = clip_link(next_rd);

   always_comb begin
      state_in  = state_ff;
      kind_in   = kind_ff;
      node_in   = node_ff;
      tail_in   = tail_ff;
      front_in  = front_ff;
      count_in  = count_ff;
      pv_in     = pv_ff;
      nv_in     = nv_ff;
      strobe_in = 1'b0;
      next_req  = '0;
      prev_req  = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               kind_in        = iol_kind_type'(req_kind);
               node_in        = req_node_index;
               next_req.re    = 1'b1;
               next_req.raddr = LinkW'(req_node_index);
               prev_req.re    = 1'b1;
               prev_req.raddr = LinkW'(req_node_index);
               state_in       = ST_LINK;
            end
         end
         ST_LINK: begin
            // links of the node are valid here
            pv_in = prev_rd;
            nv_in = next_rd;
            if (kind_ff == KIND_UNLINK || kind_ff == KIND_MOVE) begin
               next_req.we    = 1'b1;
               next_req.waddr = p_link;
               next_req.wdata = n_link;
               prev_req.we    = 1'b1;
               prev_req.waddr = n_link;
               prev_req.wdata = p_link;
               if (count_ff != '0) begin
                  count_in = count_ff - CountW'(1);
               end
               if (tail_ff == node_link) begin
                  tail_in = p_link;
               end
               if (p_link == HeadIdx) begin
                  front_in = n_link;
               end
            end
            if (kind_ff == KIND_APPEND || kind_ff == KIND_MOVE) begin
               state_in = ST_APPEND;
            end else begin
               state_in = ST_RESP;
            end
         end
         ST_APPEND: begin
            next_req.we    = 1'b1;
            next_req.waddr = node_link;
            next_req.wdata = EndIdx;
            prev_req.we    = 1'b1;
            prev_req.waddr = node_link;
            prev_req.wdata = tail_ff;
            if (count_ff != CountMax) begin
               count_in = count_ff + CountW'(1);
            end
            pv_in    = tail_ff;
            // appending the tail itself leaves it pointing at itself
            nv_in    = (tail_ff == node_link) ? node_link : EndIdx;
            state_in = ST_TAILW;
         end
         ST_TAILW: begin
            next_req.we    = 1'b1;
            next_req.waddr = tail_ff;
            next_req.wdata = node_link;
            if (tail_ff == HeadIdx) begin
               front_in = node_link;
            end
            tail_in  = node_link;
            state_in = ST_RESP;
         end
         ST_RESP: begin
            strobe_in = 1'b1;
            state_in  = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         tail_ff   <= HeadIdx;
         front_ff  <= EndIdx;
         count_ff  <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         tail_ff   <= tail_in;
         front_ff  <= front_in;
         count_ff  <= count_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
      node_ff <= node_in;
      pv_ff   <= pv_in;
      nv_ff   <= nv_in;
      if (state_ff == ST_RESP) begin
         rsp_front_ff <= front_ff;
         rsp_tail_ff  <= tail_ff;
         rsp_count_ff <= count_ff;
         rsp_prev_ff  <= pv_ff;
         rsp_next_ff  <= nv_ff;
      end
   end

   assign busy           = (state_ff != ST_IDLE);
   assign rsp_strobe     = strobe_ff;
   assign rsp_front_node = rsp_front_ff;
   assign rsp_tail_node  = rsp_tail_ff;
   assign rsp_node_count = rsp_count_ff;
   assign rsp_prev_node  = rsp_prev_ff;
   assign rsp_next_node  = rsp_next_ff;

endmodule

// ===== src/indexed_doubly_linked_order_list_unit.sv =====
`timescale 1ns / 1ps

// Ordered list of node indices kept as a doubly linked list in two link
// memories (next and prev), with a head sentinel at index NODES and an end
// sentinel at NODES+1. Typical use: recency order.
//
// Request channel: drive req_kind / req_node_index with start; the transfer
// happens on a clock edge where start is high and busy is low. Kinds: unlink,
// append at back, move to back, read links. Membership is not checked.
//
// Result channel: one transfer per request, rsp_strobe high for exactly one
// cycle with front, tail, count and the node's prev/next after the operation.
// The receiver has no way to stall; the result must be taken when shown.
//
// Sequence: a registered read of the node's links; unlink and move to back
// then splice the node out, append and move to back write node and tail links,
// and the result follows. A new request can be taken at the edge that ends the
// strobe cycle, not while one is in progress. The next-link memory sees a
// read-modify-write sequence: one registered read, then up to three writes.
//
// Reset (synchronous): empty list, tail = head, front = end, count 0. Link
// memory contents are not cleared; the head's next link lives in a register.

module indexed_doubly_linked_order_list_unit import iol_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [KindW-1:0]  req_kind,
   input  logic [IdxW-1:0]   req_node_index,
   output logic              rsp_strobe,
   output logic [LinkW-1:0]  rsp_front_node,
   output logic [LinkW-1:0]  rsp_tail_node,
   output logic [CountW-1:0] rsp_node_count,
   output logic [LinkW-1:0]  rsp_prev_node,
   output logic [LinkW-1:0]  rsp_next_node
);

   iol_mem_req_type  next_req;
   iol_mem_req_type  prev_req;
   logic [LinkW-1:0] next_rd;
   logic [LinkW-1:0] prev_rd;

   // sequencer: owns tail, count, front and the result registers
   iol_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_kind       (req_kind),
      .req_node_index (req_node_index),
      .next_req       (next_req),
      .prev_req       (prev_req),
      .next_rd        (next_rd),
      .prev_rd        (prev_rd),
      .rsp_strobe     (rsp_strobe),
      .rsp_front_node (rsp_front_node),
      .rsp_tail_node  (rsp_tail_node),
      .rsp_node_count (rsp_node_count),
      .rsp_prev_node  (rsp_prev_node),
      .rsp_next_node  (rsp_next_node)
   );

   // next links, indexed by node or sentinel
   iol_link_mem u_next_mem (
      .clock   (clock),
      .req     (next_req),
      .rd_data (next_rd)
   );

   // prev links
   iol_link_mem u_prev_mem (
      .clock   (clock),
      .req     (prev_req),
      .rd_data (prev_rd)
   );

endmodule

// ===== src/iol_checker.sv =====
`timescale 1ns / 1ps

module iol_checker import iol_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input logic              rsp_strobe,
   input logic [CountW-1:0] rsp_node_count
);

   // a taken request keeps the block busy in the next cycle
   a_take_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy not raised after request transfer");

   // busy only starts from a request transfer
   a_busy_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |-> $past(start))
      else $error("busy rose without a request");

   // one strobe per item, and the block is free again when it shows
   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (!busy && !$past(rsp_strobe)))
      else $error("result strobe while busy or repeated");

   // count never exceeds the node space
   a_count_max: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_node_count <= CountMax))
      else $error("node count above limit");

endmodule

bind indexed_doubly_linked_order_list_unit iol_checker u_iol_checker (.*);

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps

// Bench for the indexed doubly linked order list unit.
// Stimulus is driven at rising edges with nonblocking assignments; a request
// transfer happens at an edge with start high and busy low. At that edge the
// list predictor is advanced and its view of the list is queued; every result
// strobe is then checked field by field against the oldest queued view.

module testbench;
   import iol_pkg::*;

   // what one result transfer shows: list ends, count and the asked node's links
   typedef struct packed {
      logic [LinkW-1:0]  front;
      logic [LinkW-1:0]  tail;
      logic [CountW-1:0] count;
      logic [LinkW-1:0]  pred;
      logic [LinkW-1:0]  succ;
   } list_view_type;

   // how the stimulus picks a node
   typedef enum {PICK_MEMBER, PICK_FREE, PICK_SEEN} pick_rule_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic [KindW-1:0]  req_kind = KIND_READ;
   logic [IdxW-1:0]   req_node_index = '0;
   logic              busy;
   logic              rsp_strobe;
   logic [LinkW-1:0]  rsp_front_node;
   logic [LinkW-1:0]  rsp_tail_node;
   logic [CountW-1:0] rsp_node_count;
   logic [LinkW-1:0]  rsp_prev_node;
   logic [LinkW-1:0]  rsp_next_node;

   indexed_doubly_linked_order_list_unit dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_kind       (req_kind),
      .req_node_index (req_node_index),
      .rsp_strobe     (rsp_strobe),
      .rsp_front_node (rsp_front_node),
      .rsp_tail_node  (rsp_tail_node),
      .rsp_node_count (rsp_node_count),
      .rsp_prev_node  (rsp_prev_node),
      .rsp_next_node  (rsp_next_node)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // Predictor copy of the list: two link arrays, tail register and count.
   logic [LinkW-1:0]  succ_link [Links];
   logic [LinkW-1:0]  pred_link [Links];
   logic [LinkW-1:0]  last_node;
   logic [CountW-1:0] linked_total;

   list_view_type expected_views [$];

   // Stimulus bookkeeping: intended membership, and which nodes ever had
   // their links written (reading any other node's links is never caused).
   bit on_list [NODES];
   bit ever_linked [NODES];
   int on_list_total = 0;

   int burst_left = 0;
   int kind_seen [4] = '{default: 0};
   int sent_total = 0;
   int checked_total = 0;
   int errors = 0;

   function automatic void clear_model();
      foreach (succ_link[i]) begin
         succ_link[i] = '0;
         pred_link[i] = '0;
      end
      succ_link[HeadIdx] = EndIdx;
      last_node = HeadIdx;
      linked_total = '0;
   endfunction

   // splice a node out; its own entries stay as they were
   function automatic void detach(input logic [LinkW-1:0] x);
      logic [LinkW-1:0] p;
      logic [LinkW-1:0] n;
      p = pred_link[x];
      n = succ_link[x];
      if (linked_total != 0) linked_total--;
      succ_link[p] = n;
      pred_link[n] = p;
      if (last_node == x) last_node = p;
   endfunction

   // link after the tail; write order matters when x already is the tail
   function automatic void attach_back(input logic [LinkW-1:0] x);
      if (linked_total < CountMax) linked_total++;
      succ_link[x] = EndIdx;
      pred_link[x] = last_node;
      succ_link[last_node] = x;
      last_node = x;
   endfunction

   // A 6-bit index always names a real node, so the out-of-range case
   // (head/end reported, nothing changed) cannot be reached at this size.
   function automatic list_view_type predict_view(input iol_kind_type kind,
                                                  input logic [IdxW-1:0] node);
      logic [LinkW-1:0] x;
      list_view_type v;
      x = LinkW'(node);
      case (kind)
         KIND_UNLINK: detach(x);
         KIND_APPEND: attach_back(x);
         KIND_MOVE: begin
            detach(x);
            attach_back(x);
         end
         default: ;
      endcase
      v.front = succ_link[HeadIdx];
      v.tail  = last_node;
      v.count = linked_total;
      v.pred  = pred_link[x];
      v.succ  = succ_link[x];
      return v;
   endfunction

   function automatic logic [IdxW-1:0] pick_node(input pick_rule_type rule);
      logic [IdxW-1:0] n;
      bit hit;
      do begin
         n = IdxW'($urandom_range(0, NODES - 1));
         case (rule)
            PICK_MEMBER: hit = on_list[n];
            PICK_FREE:   hit = !on_list[n];
            default:     hit = ever_linked[n];
         endcase
      end while (!hit);
      return n;
   endfunction

   // Sender pacing: bursts of random length, then a gap (often none, so
   // back-to-back stretches happen, now and then a long one).
   task automatic pace();
      int gap;
      burst_left--;
      if (burst_left <= 0) begin
         burst_left = $urandom_range(1, 16);
         case ($urandom_range(0, 9))
            0, 1, 2: gap = 0;
            9:       gap = $urandom_range(8, 30);
            default: gap = $urandom_range(1, 7);
         endcase
         if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // One request transfer. start stays high on return so the next request
   // can follow without a dead cycle; pace() lowers it for a gap.
   task automatic send_transfer(input iol_kind_type kind, input logic [IdxW-1:0] node);
      start          <= 1'b1;
      req_kind       <= kind;
      req_node_index <= node;
      do @(posedge clock); while (busy);
      expected_views = {expected_views, predict_view(kind, node)};
      kind_seen[kind]++;
      sent_total++;
      case (kind)
         KIND_UNLINK: begin
            if (on_list[node]) on_list_total--;
            on_list[node] = 1'b0;
         end
         KIND_APPEND, KIND_MOVE: begin
            if (!on_list[node]) on_list_total++;
            on_list[node] = 1'b1;
            ever_linked[node] = 1'b1;
         end
         default: ;
      endcase
      pace();
   endtask

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
         errors++;
      end
   endfunction

   // Result side: the receiver cannot stall, so every strobe is a transfer.
   always @(posedge clock) begin
      list_view_type want;
      if (!reset && rsp_strobe) begin
         if (expected_views.size() == 0) begin
            $display("%0t: result transfer with nothing expected", $time);
            errors++;
         end else begin
            want = expected_views[0];
            expected_views.delete(0);
            check_field("front_node", 32'(want.front), 32'(rsp_front_node));
            check_field("tail_node", 32'(want.tail), 32'(rsp_tail_node));
            check_field("node_count", 32'(want.count), 32'(rsp_node_count));
            check_field("prev_node", 32'(want.pred), 32'(rsp_prev_node));
            check_field("next_node", 32'(want.succ), 32'(rsp_next_node));
            checked_total++;
         end
      end
   end

   // Ends of the index range, each kind, tail and front removal, emptying,
   // the count floor and stale links of unlinked nodes.
   task automatic test_list_edges();
      send_transfer(KIND_APPEND, 6'd0);     // first node into an empty list
      send_transfer(KIND_APPEND, 6'd63);
      send_transfer(KIND_APPEND, 6'd31);
      send_transfer(KIND_READ,   6'd0);
      send_transfer(KIND_MOVE,   6'd0);     // front node to back
      send_transfer(KIND_MOVE,   6'd0);     // tail moved onto itself
      send_transfer(KIND_UNLINK, 6'd0);     // tail unlink, tail steps back
      send_transfer(KIND_READ,   6'd0);     // unlinked node keeps its links
      send_transfer(KIND_UNLINK, 6'd63);    // front unlink
      send_transfer(KIND_UNLINK, 6'd31);    // list now empty
      send_transfer(KIND_UNLINK, 6'd31);    // count must not wrap below zero
      send_transfer(KIND_READ,   6'd63);
      send_transfer(KIND_APPEND, 6'd42);    // alternating index bits
      send_transfer(KIND_APPEND, 6'd21);
      send_transfer(KIND_MOVE,   6'd42);
      send_transfer(KIND_READ,   6'd21);
      send_transfer(KIND_READ,   6'd42);
   endtask

   // Well-formed traffic with random content. The append share is re-drawn
   // every 60 items so the list drifts between empty and full.
   task automatic test_random_traffic(input int items);
      int r;
      int grow;
      grow = 30;
      for (int i = 0; i < items; i++) begin
         if (i % 60 == 0) grow = $urandom_range(10, 45);
         r = $urandom_range(0, 99);
         if (on_list_total == 0 || (r < grow && on_list_total < NODES))
            send_transfer(KIND_APPEND, pick_node(PICK_FREE));
         else if (r < grow + 30)
            send_transfer(KIND_UNLINK, pick_node(PICK_MEMBER));
         else if (r < 85)
            send_transfer(KIND_MOVE, pick_node(PICK_MEMBER));
         else
            send_transfer(KIND_READ, pick_node(PICK_SEEN));  // members or not
      end
   endtask

   // Misuse the block does not guard against: full list plus duplicate
   // appends (count ceiling, tail linking to itself), then any kind on any
   // node. Every node has been written by now, so no unwritten entry is read.
   task automatic test_membership_misuse();
      while (on_list_total < NODES)
         send_transfer(KIND_APPEND, pick_node(PICK_FREE));
      send_transfer(KIND_APPEND, pick_node(PICK_MEMBER));
      send_transfer(KIND_APPEND, last_node[IdxW-1:0]);
      send_transfer(KIND_READ, last_node[IdxW-1:0]);
      send_transfer(KIND_UNLINK, 6'd5);
      send_transfer(KIND_UNLINK, 6'd5);
      repeat (40)
         send_transfer(iol_kind_type'($urandom_range(0, 3)),
                       IdxW'($urandom_range(0, NODES - 1)));
   endtask

   initial begin
      clear_model();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_list_edges();
      test_random_traffic(620);
      test_membership_misuse();

      start <= 1'b0;
      while (expected_views.size() != 0) @(posedge clock);
      // watch a while longer for stray strobes
      repeat (12) @(posedge clock);

      $display("covered %0d requests: %0d unlink, %0d append, %0d move, %0d read links",
               sent_total, kind_seen[KIND_UNLINK], kind_seen[KIND_APPEND],
               kind_seen[KIND_MOVE], kind_seen[KIND_READ]);
      $display("%0d results compared against the list predictor, %0d errors",
               checked_total, errors);
      if (errors == 0 && expected_views.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   // watchdog: a correct run needs well under 50 us
   initial begin
      #1000000;
      $display("simulation failed");
      $finish;
   end

endmodule

// ===== filelist.f =====
src/iol_pkg.sv
src/iol_link_mem.sv
src/iol_ctrl.sv
src/indexed_doubly_linked_order_list_unit.sv
src/iol_checker.sv
bench/testbench.sv
